/* rtl/gpio_pkg.sv */
`default_nettype none
package gpio_pkg;
    localparam int DefNumPorts = 11;
    localparam int PinsPerPort = 16;
    localparam int PortW = 4;

    localparam logic [1:0] REQ_READ   = 2'd0;
    localparam logic [1:0] REQ_WRITE  = 2'd1;
    localparam logic [1:0] REQ_SAMPLE = 2'd2;
    localparam logic [1:0] REQ_NONE   = 2'd3;

    localparam logic [4:0] SEL_MODE   = 5'd0;
    localparam logic [4:0] SEL_OTYPE  = 5'd1;
    localparam logic [4:0] SEL_SPEED  = 5'd2;
    localparam logic [4:0] SEL_PULL   = 5'd3;
    localparam logic [4:0] SEL_INPUT  = 5'd4;
    localparam logic [4:0] SEL_OUTPUT = 5'd5;
    localparam logic [4:0] SEL_BSRR   = 5'd6;
    localparam logic [4:0] SEL_AFL    = 5'd7;
    localparam logic [4:0] SEL_AFH    = 5'd8;
    localparam logic [4:0] SEL_MASK   = 5'd9;
    localparam logic [4:0] SEL_RISE   = 5'd10;
    localparam logic [4:0] SEL_FALL   = 5'd11;
    localparam logic [4:0] SEL_PEND   = 5'd12;
    localparam logic [4:0] SEL_SRC0   = 5'd13;
    localparam logic [4:0] SEL_SRC3   = 5'd16;

    // one memory word per port
    typedef struct packed {
        logic [31:0] mode;
        logic [15:0] otype;
        logic [31:0] speed;
        logic [31:0] pull;
        logic [15:0] odata;
        logic [63:0] af;
        logic [15:0] last;
    } port_word_t;

    // request carried from accept to memory stage
    typedef struct packed {
        logic        valid;
        logic [1:0]  req;
        logic [3:0]  port;
        logic        pv;
        logic [4:0]  sel;
        logic [31:0] wdata;
        logic [15:0] levels;
    } stage_t;
endpackage
`default_nettype wire

/* rtl/gpio_port_mem.sv */
`default_nettype none
module gpio_port_mem #(
    parameter int NUM_PORTS = gpio_pkg::DefNumPorts
) (
    input  wire                     aclk,
    input  wire                     rd_en,
    input  wire [gpio_pkg::PortW-1:0] rd_addr,
    output gpio_pkg::port_word_t    rd_data,
    input  wire                     wr_en,
    input  wire [gpio_pkg::PortW-1:0] wr_addr,
    input  gpio_pkg::port_word_t    wr_data
);
    import gpio_pkg::*;

    port_word_t mem [NUM_PORTS];

    // synchronous write and registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule
`default_nettype wire

/* rtl/gpio_port_with_edge_interrupts_core.sv */
// an accepted transaction passes the request register st_reg, then the output register
// throughput: one transaction per cycle; s_ready drops while the skid register is
// full or is about to take a result that the output register cannot pass on
// reset: synchronous active-low aresetn; port memory is cleared by a sweep over all
// NUM_PORTS words after reset, during which s_ready stays low
// global interrupt registers clear at once on reset
`default_nettype none
module gpio_port_with_edge_interrupts_core #(
    parameter int NUM_PORTS = gpio_pkg::DefNumPorts
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_valid,
    output logic        s_ready,
    input  wire  [1:0]  s_req_type,
    input  wire  [3:0]  s_port_index,
    input  wire  [4:0]  s_reg_sel,
    input  wire  [31:0] s_write_data,
    input  wire  [15:0] s_pin_levels,
    output logic        m_valid,
    input  wire         m_ready,
    output logic [31:0] m_read_data,
    output logic [6:0]  m_irq_requests,
    output logic [3:0]  m_lowest_pending_line,
    output logic [15:0] m_drive_level,
    output logic [15:0] m_drive_enable
);
    import gpio_pkg::*;

    localparam int ResW = 32 + 7 + 4 + 16 + 16;

    stage_t      st_reg, st_next;
    logic        clr_reg;
    logic [3:0]  clr_cnt_reg;
    logic [15:0] mask_reg, rise_reg, fall_reg, pend_reg;
    logic [15:0] mask_next, rise_next, fall_next, pend_next;
    logic [3:0]  src_reg [16];
    logic [3:0]  src_next [16];
    logic        fw_valid_reg;
    logic [3:0]  fw_port_reg;
    port_word_t  fw_word_reg;

    port_word_t  mem_rd, cur, upd;
    logic        mem_wr;
    logic [3:0]  mem_wa;
    port_word_t  mem_wd;

    logic [ResW-1:0] out_reg, skid_reg, res;
    logic        out_v_reg, skid_v_reg;
    logic        accept, adv;

    gpio_port_mem #(.NUM_PORTS(NUM_PORTS)) u_mem (
        .aclk(aclk), .rd_en(accept), .rd_addr(s_port_index), .rd_data(mem_rd),
        .wr_en(mem_wr), .wr_addr(mem_wa), .wr_data(mem_wd)
    );

    // input can go while skid is free and will not be filled this cycle
    assign s_ready = !clr_reg && !skid_v_reg && !(st_reg.valid && out_v_reg && !m_ready);
    assign accept  = s_valid && s_ready;
    assign adv     = st_reg.valid;

    always_comb begin
        st_next        = '0;
        st_next.valid  = accept;
        st_next.req    = s_req_type;
        st_next.port   = s_port_index;
        st_next.pv     = ({28'd0, s_port_index} < NUM_PORTS);
        st_next.sel    = s_reg_sel;
        st_next.wdata  = s_write_data;
        st_next.levels = s_pin_levels;
    end

    // forward last written word to same port back to back
    assign cur = (fw_valid_reg && fw_port_reg == st_reg.port) ? fw_word_reg : mem_rd;

    // read modify write of the port word and the global registers
    always_comb begin
        logic [15:0] lo, rising, falling, hit, act;
        logic [31:0] rd;
        logic [6:0]  irq;
        logic [3:0]  low;
        logic [15:0] den;
        lo  = st_reg.wdata[15:0];
        upd = cur;
        mask_next = mask_reg; rise_next = rise_reg; fall_next = fall_reg;
        pend_next = pend_reg;
        for (int i = 0; i < 16; i++) src_next[i] = src_reg[i];
        rd = '0;
        rising  = st_reg.levels & ~cur.last;
        falling = ~st_reg.levels & cur.last;
        hit = (rising & rise_reg) | (falling & fall_reg);
        if (st_reg.req == REQ_READ) begin
            if (st_reg.sel >= SEL_SRC0 && st_reg.sel <= SEL_SRC3) begin
                for (int k = 0; k < 4; k++)
                    rd[4*k +: 4] = src_reg[{st_reg.sel[1:0] - 2'd1, 2'(k)}];
            end else begin
                case (st_reg.sel)
                    SEL_MASK:   rd = {16'd0, mask_reg};
                    SEL_RISE:   rd = {16'd0, rise_reg};
                    SEL_FALL:   rd = {16'd0, fall_reg};
                    SEL_PEND:   rd = {16'd0, pend_reg};
                    SEL_MODE:   rd = st_reg.pv ? cur.mode : '0;
                    SEL_OTYPE:  rd = st_reg.pv ? {16'd0, cur.otype} : '0;
                    SEL_SPEED:  rd = st_reg.pv ? cur.speed : '0;
                    SEL_PULL:   rd = st_reg.pv ? cur.pull : '0;
                    SEL_INPUT:  rd = st_reg.pv ? {16'd0, cur.last} : '0;
                    SEL_OUTPUT: rd = st_reg.pv ? {16'd0, cur.odata} : '0;
                    SEL_AFL:    rd = st_reg.pv ? cur.af[31:0] : '0;
                    SEL_AFH:    rd = st_reg.pv ? cur.af[63:32] : '0;
                    default:    rd = '0;
                endcase
            end
        end else if (st_reg.req == REQ_WRITE) begin
            if (st_reg.sel >= SEL_SRC0 && st_reg.sel <= SEL_SRC3) begin
                for (int k = 0; k < 4; k++)
                    src_next[{st_reg.sel[1:0] - 2'd1, 2'(k)}] = st_reg.wdata[4*k +: 4];
            end else begin
                case (st_reg.sel)
                    SEL_MASK:   mask_next = lo;
                    SEL_RISE:   rise_next = lo;
                    SEL_FALL:   fall_next = lo;
                    SEL_PEND:   pend_next = pend_reg & ~lo;
                    SEL_MODE:   upd.mode = st_reg.wdata;
                    SEL_OTYPE:  upd.otype = lo;
                    SEL_SPEED:  upd.speed = st_reg.wdata;
                    SEL_PULL:   upd.pull = st_reg.wdata;
                    SEL_OUTPUT: upd.odata = lo;
                    SEL_BSRR:   upd.odata = (cur.odata & ~st_reg.wdata[31:16]) | lo;
                    SEL_AFL:    upd.af[31:0] = st_reg.wdata;
                    SEL_AFH:    upd.af[63:32] = st_reg.wdata;
                    default:    upd = cur;
                endcase
            end
        end else if (st_reg.req == REQ_SAMPLE && st_reg.pv) begin
            upd.last = st_reg.levels;
            for (int i = 0; i < 16; i++)
                if (src_reg[i] == st_reg.port && hit[i]) pend_next[i] = 1'b1;
        end
        act = pend_next & mask_next;
        irq = {|act[15:10], |act[9:5], act[4:0]};
        low = '0;
        for (int i = 15; i >= 0; i--) if (act[i]) low = 4'(i);
        den = '0;
        for (int i = 0; i < PinsPerPort; i++)
            if (upd.mode[2*i +: 2] == 2'b01 && (!upd.otype[i] || !upd.odata[i]))
                den[i] = 1'b1;
        if (!st_reg.pv) den = '0;
        res = {rd, irq, low, st_reg.pv ? upd.odata : 16'd0, den};
    end

    // memory write port: clearing sweep or write back
    always_comb begin
        mem_wr = clr_reg || (adv && st_reg.pv);
        mem_wa = clr_reg ? clr_cnt_reg : st_reg.port;
        mem_wd = clr_reg ? '0 : upd;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg       <= '0;
            clr_reg      <= 1'b1;
            clr_cnt_reg  <= '0;
            mask_reg <= '0; rise_reg <= '0; fall_reg <= '0; pend_reg <= '0;
            for (int i = 0; i < 16; i++) src_reg[i] <= '0;
            fw_valid_reg <= 1'b0;
            out_v_reg    <= 1'b0;
            skid_v_reg   <= 1'b0;
        end else begin
            st_reg <= st_next;
            if (clr_reg) begin
                clr_cnt_reg <= clr_cnt_reg + 4'd1;
                if (clr_cnt_reg == 4'(NUM_PORTS - 1)) clr_reg <= 1'b0;
            end
            if (adv) begin
                mask_reg <= mask_next; rise_reg <= rise_next;
                fall_reg <= fall_next; pend_reg <= pend_next;
                for (int i = 0; i < 16; i++) src_reg[i] <= src_next[i];
            end
            fw_valid_reg <= adv && st_reg.pv;
            // output register with skid
            if (adv && out_v_reg && !m_ready) begin
                skid_v_reg <= 1'b1;
            end else if (m_ready) begin
                skid_v_reg <= 1'b0;
            end
            if (!out_v_reg || m_ready) begin
                out_v_reg <= adv || skid_v_reg;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        fw_port_reg <= st_reg.port;
        fw_word_reg <= upd;
        if (adv && out_v_reg && !m_ready) skid_reg <= res;
        if (!out_v_reg || m_ready) out_reg <= skid_v_reg ? skid_reg : res;
    end

    assign m_valid = out_v_reg;
    assign {m_read_data, m_irq_requests, m_lowest_pending_line, m_drive_level,
            m_drive_enable} = out_reg;
endmodule
`default_nettype wire

/* test/tb.sv */
`timescale 1ns / 1ps
`default_nettype none

// scoreboard: gpio state mirror plus queue of expected results
class gpio_scoreboard;
    typedef struct packed {
        logic [31:0] rdata;
        logic [6:0]  irq;
        logic [3:0]  lowest;
        logic [15:0] dlev;
        logic [15:0] den;
    } gpio_result_t;

    logic [31:0] mode_r[11];
    logic [15:0] otype_r[11];
    logic [31:0] speed_r[11];
    logic [31:0] pull_r[11];
    logic [15:0] odata_r[11];
    logic [63:0] af_r[11];
    logic [15:0] last_r[11];
    logic [15:0] mask_r, rise_r, fall_r, pend_r;
    logic [3:0]  src_r[16];
    gpio_result_t expected_q[$];
    int errors;
    int checked;

    function new();
        for (int p = 0; p < 11; p++) begin
            mode_r[p] = '0; otype_r[p] = '0; speed_r[p] = '0; pull_r[p] = '0;
            odata_r[p] = '0; af_r[p] = '0; last_r[p] = '0;
        end
        for (int i = 0; i < 16; i++) src_r[i] = '0;
        mask_r = '0; rise_r = '0; fall_r = '0; pend_r = '0;
        errors = 0;
        checked = 0;
    endfunction

    function logic [31:0] reg_value(bit pv, int p, logic [4:0] sel);
        logic [31:0] v;
        v = '0;
        if (sel >= gpio_pkg::SEL_SRC0 && sel <= gpio_pkg::SEL_SRC3) begin
            for (int k = 0; k < 4; k++) v[4*k +: 4] = src_r[(sel - gpio_pkg::SEL_SRC0)*4 + k];
            return v;
        end
        case (sel)
            gpio_pkg::SEL_MASK: return {16'h0, mask_r};
            gpio_pkg::SEL_RISE: return {16'h0, rise_r};
            gpio_pkg::SEL_FALL: return {16'h0, fall_r};
            gpio_pkg::SEL_PEND: return {16'h0, pend_r};
            default: ;
        endcase
        if (!pv) return '0;
        case (sel)
            gpio_pkg::SEL_MODE:   v = mode_r[p];
            gpio_pkg::SEL_OTYPE:  v = {16'h0, otype_r[p]};
            gpio_pkg::SEL_SPEED:  v = speed_r[p];
            gpio_pkg::SEL_PULL:   v = pull_r[p];
            gpio_pkg::SEL_INPUT:  v = {16'h0, last_r[p]};
            gpio_pkg::SEL_OUTPUT: v = {16'h0, odata_r[p]};
            gpio_pkg::SEL_AFL:    v = af_r[p][31:0];
            gpio_pkg::SEL_AFH:    v = af_r[p][63:32];
            default:              v = '0;
        endcase
        return v;
    endfunction

    function void write_reg(bit pv, int p, logic [4:0] sel, logic [31:0] wd);
        if (sel >= gpio_pkg::SEL_SRC0 && sel <= gpio_pkg::SEL_SRC3) begin
            for (int k = 0; k < 4; k++) src_r[(sel - gpio_pkg::SEL_SRC0)*4 + k] = wd[4*k +: 4];
            return;
        end
        case (sel)
            gpio_pkg::SEL_MASK: begin mask_r = wd[15:0]; return; end
            gpio_pkg::SEL_RISE: begin rise_r = wd[15:0]; return; end
            gpio_pkg::SEL_FALL: begin fall_r = wd[15:0]; return; end
            gpio_pkg::SEL_PEND: begin pend_r = pend_r & ~wd[15:0]; return; end
            default: ;
        endcase
        if (!pv) return;
        case (sel)
            gpio_pkg::SEL_MODE:   mode_r[p] = wd;
            gpio_pkg::SEL_OTYPE:  otype_r[p] = wd[15:0];
            gpio_pkg::SEL_SPEED:  speed_r[p] = wd;
            gpio_pkg::SEL_PULL:   pull_r[p] = wd;
            gpio_pkg::SEL_OUTPUT: odata_r[p] = wd[15:0];
            // set wins over reset
            gpio_pkg::SEL_BSRR:   odata_r[p] = (odata_r[p] & ~wd[31:16]) | wd[15:0];
            gpio_pkg::SEL_AFL:    af_r[p][31:0] = wd;
            gpio_pkg::SEL_AFH:    af_r[p][63:32] = wd;
            default: ;
        endcase
    endfunction

    // note one accepted input transaction
    function void note_request(logic [1:0] rt, logic [3:0] port, logic [4:0] sel,
                               logic [31:0] wd, logic [15:0] lv);
        gpio_result_t r;
        bit pv;
        int p;
        logic [15:0] hit, act;
        pv = port < 11;
        p = pv ? int'(port) : 0;
        r = '0;
        if (rt == gpio_pkg::REQ_READ) r.rdata = reg_value(pv, p, sel);
        else if (rt == gpio_pkg::REQ_WRITE) write_reg(pv, p, sel, wd);
        else if (rt == gpio_pkg::REQ_SAMPLE && pv) begin
            hit = ((lv & ~last_r[p]) & rise_r) | ((~lv & last_r[p]) & fall_r);
            for (int i = 0; i < 16; i++)
                if (src_r[i] == port && hit[i]) pend_r[i] = 1'b1;
            last_r[p] = lv;
        end
        act = pend_r & mask_r;
        r.irq = {|act[15:10], |act[9:5], act[4:0]};
        for (int i = 15; i >= 0; i--) if (act[i]) r.lowest = i[3:0];
        if (pv) begin
            r.dlev = odata_r[p];
            for (int i = 0; i < 16; i++)
                if (mode_r[p][2*i +: 2] == 2'b01 && (!otype_r[p][i] || !r.dlev[i]))
                    r.den[i] = 1'b1;
        end
        expected_q.push_back(r);
    endfunction

    // compare one result transaction with the oldest expectation
    function void check_result(logic [31:0] rd, logic [6:0] irq, logic [3:0] low,
                               logic [15:0] dl, logic [15:0] de);
        gpio_result_t e;
        if (expected_q.size() == 0) begin
            $error("result with no expectation pending");
            errors++;
            return;
        end
        e = expected_q.pop_front();
        checked++;
        if (rd !== e.rdata) begin
            $error("read_data exp %h got %h", e.rdata, rd); errors++;
        end
        if (irq !== e.irq) begin
            $error("irq_requests exp %h got %h", e.irq, irq); errors++;
        end
        if (low !== e.lowest) begin
            $error("lowest_pending_line exp %0d got %0d", e.lowest, low); errors++;
        end
        if (dl !== e.dlev) begin
            $error("drive_level exp %h got %h", e.dlev, dl); errors++;
        end
        if (de !== e.den) begin
            $error("drive_enable exp %h got %h", e.den, de); errors++;
        end
    endfunction
endclass

module tb;
    import gpio_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_req_type = '0;
    logic [3:0]  s_port_index = '0;
    logic [4:0]  s_reg_sel = '0;
    logic [31:0] s_write_data = '0;
    logic [15:0] s_pin_levels = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_read_data;
    logic [6:0]  m_irq_requests;
    logic [3:0]  m_lowest_pending_line;
    logic [15:0] m_drive_level;
    logic [15:0] m_drive_enable;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_off_cycles = 0;
    bit stim_done = 1'b0;
    int sent = 0;

    gpio_scoreboard gpio_sb = new();

    gpio_port_with_edge_interrupts_core i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_req_type(s_req_type), .s_port_index(s_port_index), .s_reg_sel(s_reg_sel),
        .s_write_data(s_write_data), .s_pin_levels(s_pin_levels),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_read_data(m_read_data), .m_irq_requests(m_irq_requests),
        .m_lowest_pending_line(m_lowest_pending_line),
        .m_drive_level(m_drive_level), .m_drive_enable(m_drive_enable)
    );

    // clock
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // capture accepted input transactions
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready)
            gpio_sb.note_request(s_req_type, s_port_index, s_reg_sel,
                                 s_write_data, s_pin_levels);
    end

    // check result transactions
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            gpio_sb.check_result(m_read_data, m_irq_requests, m_lowest_pending_line,
                                 m_drive_level, m_drive_enable);
    end

    // receiver ready with random stalls and an optional long hold-off
    always @(posedge aclk) begin
        if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // offer one transaction, with random idle gaps before it
    task automatic send_item(logic [1:0] rt, logic [3:0] port, logic [4:0] sel,
                             logic [31:0] wd, logic [15:0] lv);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_req_type <= rt;
        s_port_index <= port;
        s_reg_sel <= sel;
        s_write_data <= wd;
        s_pin_levels <= lv;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sent++;
    endtask

    task automatic send_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // one random transaction, biased toward well-formed interrupt activity
    task automatic send_random();
        int pick;
        logic [3:0] port;
        logic [4:0] sel;
        logic [31:0] wd;
        pick = $urandom_range(99);
        port = ($urandom_range(9) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(10));
        wd = $urandom();
        if (pick < 35) begin
            // pin sample, mostly on valid ports 0 to 10
            send_item(REQ_SAMPLE, port, 5'($urandom_range(31)), wd, 16'($urandom()));
        end else if (pick < 65) begin
            sel = ($urandom_range(15) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(16));
            send_item(REQ_WRITE, port, sel, wd, 16'($urandom()));
        end else if (pick < 97) begin
            sel = ($urandom_range(15) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(16));
            send_item(REQ_READ, port, sel, wd, 16'($urandom()));
        end else begin
            send_item(REQ_NONE, port, 5'($urandom_range(31)), wd, 16'($urandom()));
        end
    endtask

    task automatic run_phase(int n, int s_pct, int r_pct);
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        repeat (n) send_random();
        send_idle();
    endtask

    // stimulus
    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: the port and interrupt registers, extremes, special cases
        send_item(REQ_WRITE, 4'd0, SEL_MODE, 32'h5555_5555, '0);
        send_item(REQ_WRITE, 4'd0, SEL_OTYPE, 32'hFFFF_00FF, '0);
        send_item(REQ_WRITE, 4'd0, SEL_BSRR, 32'hFFFF_0F0F, '0);
        send_item(REQ_WRITE, 4'd10, SEL_OUTPUT, 32'hFFFF_FFFF, '0);
        send_item(REQ_WRITE, 4'd10, SEL_SPEED, 32'hFFFF_FFFF, '0);
        send_item(REQ_WRITE, 4'd10, SEL_PULL, 32'hAAAA_AAAA, '0);
        send_item(REQ_WRITE, 4'd10, SEL_AFL, 32'h1234_5678, '0);
        send_item(REQ_WRITE, 4'd10, SEL_AFH, 32'hFEDC_BA98, '0);
        send_item(REQ_WRITE, 4'd15, SEL_MODE, 32'hFFFF_FFFF, '0);
        send_item(REQ_WRITE, 4'd0, SEL_INPUT, 32'hFFFF_FFFF, '0);
        send_item(REQ_WRITE, 4'd15, SEL_MASK, 32'hFFFF_FFFF, '0);
        send_item(REQ_WRITE, 4'd0, SEL_RISE, 32'h0000_FFFF, '0);
        send_item(REQ_WRITE, 4'd0, SEL_FALL, 32'hFFFF_00FF, '0);
        send_item(REQ_WRITE, 4'd0, SEL_SRC0 + 5'd1, 32'hFFFF_BA00, '0);
        send_item(REQ_SAMPLE, 4'd0, '0, '0, 16'hFFFF);
        send_item(REQ_SAMPLE, 4'd0, '0, '0, 16'h0000);
        send_item(REQ_SAMPLE, 4'd10, '0, '0, 16'hFFFF);
        send_item(REQ_SAMPLE, 4'd12, '0, '0, 16'hFFFF);
        for (int s = 0; s < 32; s += 4)
            send_item(REQ_READ, 4'd10, 5'(s), '0, '0);
        send_item(REQ_READ, 4'd0, SEL_PEND, '0, '0);
        send_item(REQ_WRITE, 4'd0, SEL_PEND, 32'h0000_FFFF, '0);
        send_item(REQ_NONE, 4'd0, SEL_MODE, 32'hFFFF_FFFF, 16'hFFFF);
        send_item(REQ_READ, 4'd15, SEL_AFH, '0, '0);

        // random phases with different idling
        run_phase(550, 29, 64);
        run_phase(550, 64, 29);
        run_phase(450, 0, 0);

        // long receiver hold-off while the sender keeps offering
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_off_cycles = 60;
        repeat (120) send_random();
        send_idle();
        stim_done = 1'b1;
    end

    // end of run
    initial begin
        wait (stim_done);
        while (gpio_sb.expected_q.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        $display("covered %0d transactions, %0d results checked: reads, writes, samples,",
                 sent, gpio_sb.checked);
        $display("out-of-range ports, unused selects, edge interrupts and a long stall");
        if (gpio_sb.errors == 0 && gpio_sb.expected_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2000000;
        $display("timeout");
        $display("CHECKS FAILED");
        $finish;
    end
endmodule

`default_nettype wire

/* files.f */
rtl/gpio_pkg.sv
rtl/gpio_port_mem.sv
rtl/gpio_port_with_edge_interrupts_core.sv
test/tb.sv
